### hw/rtl/rfa_pkg.sv
package rfa_pkg;

    // Port and datapath widths
    localparam int FUNC_W            = 4;
    localparam int NUM_W             = 32;
    localparam int DEN_W             = 31;
    localparam int RES_NUM_W         = 64;
    localparam int RES_DEN_W         = 63;
    localparam int DP_W              = 5;
    localparam int PROD_W            = 64;
    localparam int DCNT_W            = $clog2(PROD_W);
    localparam int OPERAND_WIDTH_DEF = 32;

    // Reciprocal of five, exact for 32-bit dividends with a shift of 34
    localparam logic [NUM_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int               RECIP5_SHIFT = 34;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_SQR  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_RCP  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_NEG  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_EQ   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_GT   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_TERM = 4'd9;

    // Operands in sign-magnitude form
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              an;
        logic [NUM_W-1:0]  am;
        logic [DEN_W-1:0]  ad;
        logic              bn;
        logic [NUM_W-1:0]  bm;
        logic [DEN_W-1:0]  bd;
    } rfa_opnd_t;

    // One result beat
    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        logic                 flag;
        logic [DP_W-1:0]      dp;
        logic                 error;
    } rfa_res_t;

endpackage

### hw/rtl/rfa_mul.sv
module rfa_mul (
    input  logic                       clk,
    input  logic [rfa_pkg::NUM_W-1:0]  op_a,
    input  logic [rfa_pkg::NUM_W-1:0]  op_b,
    output logic [rfa_pkg::PROD_W-1:0] prod
);
    import rfa_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/rfa_core.sv
module rfa_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rfa_pkg::rfa_opnd_t opnd,
    output logic               busy,
    output logic               done,
    output rfa_pkg::rfa_res_t  res
);
    import rfa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_NEG  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_TWO  = 4'd10;
    localparam logic [3:0] S_FA   = 4'd11;
    localparam logic [3:0] S_FB   = 4'd12;

    localparam int Q_W = PROD_W - RECIP5_SHIFT;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        mcnt_reg, mcnt_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    rfa_opnd_t         opnd_reg, opnd_next;
    logic              sign_reg, sign_next;
    logic [PROD_W-1:0] n_reg, n_next;
    logic [PROD_W-1:0] d_reg, d_next;
    logic [PROD_W-1:0] t_reg, t_next;
    logic [PROD_W-1:0] u_reg, u_next;
    logic [PROD_W-1:0] v_reg, v_next;
    logic [DP_W-1:0]   p2_reg, p2_next;
    logic [DP_W-1:0]   p5_reg, p5_next;
    rfa_res_t          res_reg, res_next;
    logic              done_reg, done_next;

    logic [NUM_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] alu_a, alu_b;
    logic              alu_sub;
    logic [PROD_W:0]   alu_full;
    logic [PROD_W-1:0] alu_res;
    logic              alu_cy;
    logic [Q_W-1:0]    q5;
    logic              sbx;

    rfa_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign q5  = mul_p[PROD_W-1:RECIP5_SHIFT];
    assign sbx = opnd_reg.bn ^ (opnd_reg.func == FN_SUB);

    // Select the product pair for each multiply slot
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_FA)
        begin
            mul_a = d_reg[NUM_W-1:0];
            mul_b = RECIP5;
        end
        else if (state_reg == S_MUL)
        begin
            case (mcnt_reg)
                2'd0:
                begin
                    case (opnd_reg.func)
                        FN_MUL:  begin mul_a = opnd_reg.am; mul_b = opnd_reg.bm; end
                        FN_SQR:  begin mul_a = opnd_reg.am; mul_b = opnd_reg.am; end
                        FN_RCP:  begin mul_a = NUM_W'(opnd_reg.ad); mul_b = NUM_W'(1); end
                        FN_NEG,
                        FN_TERM: begin mul_a = opnd_reg.am; mul_b = NUM_W'(1); end
                        default: begin mul_a = opnd_reg.am; mul_b = NUM_W'(opnd_reg.bd); end
                    endcase
                end
                2'd1:
                begin
                    mul_a = opnd_reg.bm;
                    mul_b = NUM_W'(opnd_reg.ad);
                end
                2'd2:
                begin
                    case (opnd_reg.func)
                        FN_DIV:  begin mul_a = NUM_W'(opnd_reg.ad); mul_b = opnd_reg.bm; end
                        FN_SQR:  begin mul_a = NUM_W'(opnd_reg.ad);
                                       mul_b = NUM_W'(opnd_reg.ad); end
                        FN_RCP:  begin mul_a = opnd_reg.am; mul_b = NUM_W'(1); end
                        FN_NEG,
                        FN_TERM: begin mul_a = NUM_W'(opnd_reg.ad); mul_b = NUM_W'(1); end
                        default: begin mul_a = NUM_W'(opnd_reg.ad);
                                       mul_b = NUM_W'(opnd_reg.bd); end
                    endcase
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // Steer the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_SUM:
            begin
                alu_a   = n_reg;
                alu_b   = t_reg;
                alu_sub = opnd_reg.an != sbx;
            end
            S_NEG, S_OUT:
            begin
                alu_b = n_reg;
            end
            S_CMP:
            begin
                alu_a = n_reg;
                alu_b = t_reg;
            end
            S_GCD:
            begin
                alu_a = u_reg;
                alu_b = v_reg;
            end
            S_DIVN:
            begin
                alu_a = {u_reg[PROD_W-2:0], n_reg[PROD_W-1]};
                alu_b = v_reg;
            end
            S_DIVD:
            begin
                alu_a = {u_reg[PROD_W-2:0], d_reg[PROD_W-1]};
                alu_b = v_reg;
            end
            S_FB:
            begin
                alu_a   = PROD_W'({q5, 2'b00});
                alu_b   = PROD_W'(q5);
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_full = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                      (PROD_W+1)'(alu_sub);
    assign alu_res  = alu_full[PROD_W-1:0];
    assign alu_cy   = alu_full[PROD_W];

    // Sequencer
    always_comb
    begin
        logic uses_b;
        logic sl;
        logic sg;
        logic eqm;
        logic gt;
        logic term_ok;

        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        dcnt_next  = dcnt_reg;
        opnd_next  = opnd_reg;
        sign_next  = sign_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        p2_next    = p2_reg;
        p5_next    = p5_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        uses_b  = (opnd.func <= FN_DIV) || (opnd.func == FN_EQ) || (opnd.func == FN_GT);
        sl      = opnd_reg.an & (n_reg != '0);
        sg      = opnd_reg.bn & (t_reg != '0);
        eqm     = alu_res == '0;
        gt      = (sl != sg) ? !sl : (!sl ? (alu_cy && !eqm) : !alu_cy);
        term_ok = d_reg == PROD_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    opnd_next = opnd;
                    mcnt_next = '0;
                    p2_next   = '0;
                    p5_next   = '0;
                    res_next  = '{num: '0, den: RES_DEN_W'(1), flag: 1'b0,
                                  dp: '0, error: 1'b0};
                    case (opnd.func)
                        FN_MUL, FN_DIV: sign_next = opnd.an ^ opnd.bn;
                        FN_RCP:         sign_next = opnd.an;
                        FN_NEG:         sign_next = !opnd.an;
                        default:        sign_next = 1'b0;
                    endcase
                    // Finish at once on unused codes, divide-by-zero cases and a zero-numerator terminating test
                    if (opnd.func > FN_TERM)
                        done_next = 1'b1;
                    else if ((opnd.ad == '0) || (uses_b && (opnd.bd == '0)) ||
                             ((opnd.func == FN_DIV) && (opnd.bm == '0)) ||
                             ((opnd.func == FN_RCP) && (opnd.am == '0)))
                    begin
                        res_next.error = 1'b1;
                        done_next      = 1'b1;
                    end
                    else if ((opnd.func == FN_TERM) && (opnd.am == '0))
                    begin
                        res_next.flag = 1'b1;
                        done_next     = 1'b1;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd1: n_next = mul_p;
                    2'd2: t_next = mul_p;
                    2'd3:
                    begin
                        d_next = mul_p;
                        case (opnd_reg.func)
                            FN_ADD, FN_SUB: state_next = S_SUM;
                            FN_EQ, FN_GT:   state_next = S_CMP;
                            default:        state_next = S_NORM;
                        endcase
                    end
                    default: mcnt_next = 2'd1;
                endcase
            end
            S_SUM:
            begin
                n_next = alu_res;
                if (alu_sub && !alu_cy)
                begin
                    sign_next  = sbx;
                    state_next = S_NEG;
                end
                else
                begin
                    sign_next  = opnd_reg.an;
                    state_next = S_NORM;
                end
            end
            S_NEG:
            begin
                n_next     = alu_res;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (n_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    state_next = S_GCD;
                end
            end
            S_CMP:
            begin
                res_next.flag = (opnd_reg.func == FN_EQ) ? ((sl == sg) && eqm) : gt;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            S_GCD:
            begin
                // Binary gcd; common twos drop out of both parts directly
                if (u_reg == '0)
                begin
                    dcnt_next  = '0;
                    state_next = (opnd_reg.func == FN_TERM) ? S_DIVD : S_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (alu_cy)
                    u_next = alu_res >> 1;
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            S_DIVN:
            begin
                u_next    = alu_cy ? alu_res : alu_a;
                n_next    = {n_reg[PROD_W-2:0], alu_cy};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(PROD_W - 1))
                    state_next = S_DIVD;
            end
            S_DIVD:
            begin
                u_next    = alu_cy ? alu_res : alu_a;
                d_next    = {d_reg[PROD_W-2:0], alu_cy};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(PROD_W - 1))
                    state_next = (opnd_reg.func == FN_TERM) ? S_TWO : S_OUT;
            end
            S_OUT:
            begin
                res_next.num = sign_reg ? alu_res : n_reg;
                res_next.den = d_reg[RES_DEN_W-1:0];
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_TWO:
            begin
                if (!d_reg[0])
                begin
                    d_next  = d_reg >> 1;
                    p2_next = p2_reg + DP_W'(1);
                end
                else
                    state_next = S_FA;
            end
            S_FA:
            begin
                state_next = S_FB;
            end
            S_FB:
            begin
                if (alu_res == d_reg)
                begin
                    d_next     = PROD_W'(q5);
                    p5_next    = p5_reg + DP_W'(1);
                    state_next = S_FA;
                end
                else
                begin
                    res_next.flag = term_ok;
                    res_next.dp   = term_ok ? ((p2_reg > p5_reg) ? p2_reg : p5_reg) : '0;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mcnt_reg <= mcnt_next;
        dcnt_reg <= dcnt_next;
        opnd_reg <= opnd_next;
        sign_reg <= sign_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        p2_reg   <= p2_next;
        p5_reg   <= p5_next;
        res_reg  <= res_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### hw/rtl/rational_fraction_alu.sv
// Arithmetic unit for reduced fractions a = a_num/a_den and b = b_num/b_den.
// Command channel: an item is taken at a rising edge with start high and busy
// low; func selects add, subtract, multiply, divide, square, reciprocal,
// negate, equal, greater or the terminating-decimal test of a.
// Result channel: done is high for exactly one cycle with res_num, res_den,
// flag, decimal_places and error valid; there is no backpressure, the beat
// must be taken in that cycle.
// Sequence: unused codes, divide-by-zero cases and the terminating test of a
// zero numerator finish from idle; compares run the multiply phase and a
// compare step. Fraction results run the multiply phase, for add and subtract
// the signed sum (with a negate step when the difference goes negative), a
// normalize step, the binary gcd (one step per cycle), two 64-bit restoring
// divisions and an output step; a zero result skips the gcd and divisions.
// The terminating test runs the denominator division only, then strips
// factors of two and of five. Sums, compares, gcd and division steps share
// the single 64-bit adder; busy stays high until done, so the next item can start the cycle done is shown.
// Reset clears the sequencer and the done strobe; an item in flight is lost.
module rational_fraction_alu #(
    parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rfa_pkg::FUNC_W-1:0]           func,
    input  logic signed [rfa_pkg::NUM_W-1:0]     a_num,
    input  logic [rfa_pkg::DEN_W-1:0]            a_den,
    input  logic signed [rfa_pkg::NUM_W-1:0]     b_num,
    input  logic [rfa_pkg::DEN_W-1:0]            b_den,
    output logic                                 done,
    output logic signed [rfa_pkg::RES_NUM_W-1:0] res_num,
    output logic [rfa_pkg::RES_DEN_W-1:0]        res_den,
    output logic                                 flag,
    output logic [rfa_pkg::DP_W-1:0]             decimal_places,
    output logic                                 error
);
    import rfa_pkg::*;

    localparam int               SHIFT    = NUM_W - OPERAND_WIDTH;
    localparam logic [DEN_W-1:0] DEN_MASK =
        DEN_W'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

    logic signed [NUM_W-1:0] a_sh, a_sx, b_sh, b_sx;
    rfa_opnd_t               opnd;
    rfa_res_t                res;

    // Sign extend the low operand bits and split into sign and magnitude
    assign a_sh = a_num <<< SHIFT;
    assign a_sx = a_sh >>> SHIFT;
    assign b_sh = b_num <<< SHIFT;
    assign b_sx = b_sh >>> SHIFT;

    always_comb
    begin
        opnd.func = func;
        opnd.an   = a_sx[NUM_W-1];
        opnd.am   = a_sx[NUM_W-1] ? (NUM_W'(0) - a_sx) : a_sx;
        opnd.ad   = a_den & DEN_MASK;
        opnd.bn   = b_sx[NUM_W-1];
        opnd.bm   = b_sx[NUM_W-1] ? (NUM_W'(0) - b_sx) : b_sx;
        opnd.bd   = b_den & DEN_MASK;
    end

    rfa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opnd  (opnd),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    assign res_num        = res.num;
    assign res_den        = res.den;
    assign flag           = res.flag;
    assign decimal_places = res.dp;
    assign error          = res.error;

    // A beat leaves only while the sequencer is idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An accepted command either runs or answers in the next cycle
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command dropped");

    // Denominator never zero on a result beat
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_den != '0))
        else $error("zero denominator out");

    // Error beats carry the neutral fraction, no flag and no decimal places
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error) |-> ((res_num == '0) && !flag && (decimal_places == '0)))
        else $error("error beat carries data");

endmodule
